### rtl/sae_pkg.sv
// Shared types and codes for the sorted array engine.
package sae_pkg;

   // Request kinds
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX = 2'd3;

   // Register map: word index taken from paddr[2]
   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic [15:0] TOL_RESET = 16'd6;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] data_value;
      logic signed [7:0]  position;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         index_out;
      logic signed [31:0] value_out;
      logic [7:0]         fill_count;
   } rsp_item_type;

   // Command broadcast to every cell during the evaluation state
   typedef struct packed {
      logic               en_insert;
      logic               en_find;
      logic               en_remove;
      logic               en_read;
      logic signed [31:0] val;
      logic signed [33:0] lo;
      logic signed [33:0] hi;
   } cell_ctl_type;

endpackage

### rtl/sae_cell.sv
// One slot of the sorted array: holds an entry, compares it, shifts with its neighbors.
module sae_cell #(
   parameter int IDX  = 0,
   parameter int IDXW = 1,
   parameter int CW   = 1
) (
   input  logic                 clock,
   input  sae_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]        count,
   input  logic [IDXW-1:0]      key,
   input  logic signed [31:0]   left_entry,
   input  logic                 left_le,
   input  logic                 left_match,
   input  logic signed [31:0]   right_entry,
   output logic signed [31:0]   entry,
   output logic                 le,
   output logic                 match,
   output logic                 sel
);
   import sae_pkg::*;

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic signed [33:0] entry_x;
   logic               valid;
   logic               at_key;
   logic               ins_sel;

   assign entry   = entry_ff;
   assign valid   = CW'(IDX) < count;
   assign entry_x = 34'(entry_ff);
   assign le      = valid && (entry_ff <= ctl.val);
   assign match   = valid && (entry_x >= ctl.lo) && (entry_x <= ctl.hi);
   assign at_key  = key == IDXW'(IDX);

   // first slot that is not below-or-equal takes the new word
   assign ins_sel = ctl.en_insert && !le && left_le;
   assign sel     = ins_sel
                 || (ctl.en_find && match && !left_match)
                 || ((ctl.en_remove || ctl.en_read) && at_key);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.en_insert && !le) begin
         entry_in = ins_sel ? ctl.val : left_entry;
      end else if (ctl.en_remove && (IDXW'(IDX) >= key)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### rtl/sae_tree.sv
// Registered OR tree that collects the one selected cell's index and entry.
module sae_tree #(
   parameter int LEVELS = 1,
   parameter int LW     = 34
) (
   input  logic          clock,
   input  logic [LW-1:0] leaf [1 << LEVELS],
   output logic [LW-1:0] root
);
   import sae_pkg::*;

   localparam int P = 1 << LEVELS;

   logic [LW-1:0] node_ff [1:2*P-1];

   assign root = node_ff[1];

   // one level per cycle toward the root
   always_ff @(posedge clock) begin
      for (int j = P; j < 2 * P; j++) begin
         node_ff[j] <= leaf[j-P];
      end
      for (int j = 1; j < P; j++) begin
         node_ff[j] <= node_ff[2*j] | node_ff[2*j+1];
      end
   end

endmodule

### rtl/sorted_array_engine.sv
// Sorted array engine top level: request control, cell row, result tree, register port.
//
// A bounded ascending array of signed Q16.16 words. Each request word on the
// req_ channel (insert, find, remove at index, read at index) produces exactly
// one response word on the rsp_ channel with a status, an index, a value and
// the fill count after the request. Both channels use valid/ready.
// One request is in flight at a time. A request is evaluated by all cells in
// the cycle after acceptance (compare and shift in place), then the selected
// cell's index and entry climb a registered OR tree of $clog2(CAPACITY)
// levels. rsp_valid rises once the tree has drained and req_ready is high again
// in that same cycle: a new request is taken only once the last response is loaded.
// A response waiting for rsp_ready does not block the next request; a second
// finished response is parked until the first one is taken.
// Reset empties the array (fill count zero) and sets match_tolerance to 6.
// match_tolerance sits at byte address 0 of the APB port and is to be written by
// the user only while the block is idle; the block itself does not enforce this.
module sorted_array_engine #(
   parameter int CAPACITY = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sae_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sae_pkg::rsp_item_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import sae_pkg::*;

   localparam int IDXW = $clog2(CAPACITY);
   localparam int P    = 1 << IDXW;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int DCW  = $clog2(IDXW + 1);
   localparam int SW   = CW + 9;
   localparam int LW   = 1 + IDXW + 32;

   typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DRAIN, S_HOLD} state_type;

   state_type    state_ff;
   logic [1:0]   op_ff;
   logic         ok_ff;
   logic [IDXW-1:0] key_ff;
   cell_ctl_type ctl_ff;
   logic [CW-1:0]   count_ff;
   logic [DCW-1:0]  drain_ff;
   logic [15:0]     tol_ff;
   logic            rsp_valid_ff;
   rsp_item_type    rsp_data_ff;
   rsp_item_type    pend_ff;

   // request decode
   logic signed [SW-1:0] count_s;
   logic signed [SW-1:0] pos_s;
   logic signed [SW-1:0] k_s;
   logic                 full;
   logic                 idx_ok;
   logic signed [33:0]   val_x;
   logic signed [33:0]   tol_x;
   logic signed [33:0]   lo_in;
   logic signed [33:0]   hi_in;
   logic                 rsp_free;
   logic                 rsp_load;

   // cell row and tree
   logic signed [31:0] entry_w [CAPACITY];
   logic               le_w    [CAPACITY];
   logic               match_w [CAPACITY];
   logic               sel_w   [CAPACITY];
   logic [LW-1:0]      leaf_w  [P];
   logic [LW-1:0]      root_w;
   logic               root_hit;
   logic [IDXW-1:0]    root_idx;
   logic signed [31:0] root_value;

   // result
   rsp_item_type       rsp_in;
   logic [IDXW-1:0]    idx_sel;
   logic [IDXW+6:0]    idx_wide;
   logic [CW+7:0]      fill_wide;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_TOLERANCE) ? {16'd0, tol_ff} : 32'd0;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = rsp_free
                   && (((state_ff == S_DRAIN) && (drain_ff == '0)) || (state_ff == S_HOLD));

   assign count_s = signed'(SW'(count_ff));
   assign pos_s   = SW'(req_data.position);
   assign k_s     = ((req_data.req_type == OP_REMOVE) && (req_data.position < 0))
                  ? count_s + pos_s : pos_s;
   assign idx_ok  = (k_s >= 0) && (k_s < count_s);
   assign full    = count_ff == CW'(CAPACITY);
   assign val_x   = 34'(req_data.data_value);
   assign tol_x   = signed'(34'(tol_ff));
   assign lo_in   = val_x - tol_x;
   assign hi_in   = val_x + tol_x;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [31:0] left_entry;
         logic               left_le;
         logic               left_match;
         logic signed [31:0] right_entry;
         if (gi == 0) begin : g_first
            assign left_entry = '0;
            assign left_le    = 1'b1;
            assign left_match = 1'b0;
         end else begin : g_mid
            assign left_entry = entry_w[gi-1];
            assign left_le    = le_w[gi-1];
            assign left_match = match_w[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_entry = entry_w[gi];
         end else begin : g_inner
            assign right_entry = entry_w[gi+1];
         end
         sae_cell #(
            .IDX  (gi),
            .IDXW (IDXW),
            .CW   (CW)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl_ff),
            .count       (count_ff),
            .key         (key_ff),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .left_match  (left_match),
            .right_entry (right_entry),
            .entry       (entry_w[gi]),
            .le          (le_w[gi]),
            .match       (match_w[gi]),
            .sel         (sel_w[gi])
         );
      end
      for (gi = 0; gi < P; gi++) begin : g_leaf
         if (gi < CAPACITY) begin : g_used
            assign leaf_w[gi] = sel_w[gi] ? {1'b1, IDXW'(gi), entry_w[gi]} : '0;
         end else begin : g_pad
            assign leaf_w[gi] = '0;
         end
      end
   endgenerate

   sae_tree #(
      .LEVELS (IDXW),
      .LW     (LW)
   ) u_tree (
      .clock (clock),
      .leaf  (leaf_w),
      .root  (root_w)
   );

   assign root_hit   = root_w[LW-1];
   assign root_idx   = root_w[LW-2:32];
   assign root_value = root_w[31:0];

   always_comb begin
      idx_sel   = ((op_ff == OP_REMOVE) || (op_ff == OP_READ)) ? key_ff : root_idx;
      idx_wide  = {7'd0, idx_sel};
      fill_wide = {8'd0, count_ff};
      rsp_in.status     = ST_OK;
      rsp_in.index_out  = idx_wide[6:0];
      rsp_in.value_out  = '0;
      rsp_in.fill_count = fill_wide[7:0];
      case (op_ff)
         OP_INSERT: begin
            if (!ok_ff) begin
               rsp_in.status    = ST_FULL;
               rsp_in.index_out = '0;
            end
         end
         OP_FIND: begin
            if (!root_hit) begin
               rsp_in.status    = ST_NOT_FOUND;
               rsp_in.index_out = '0;
            end
         end
         default: begin
            if (ok_ff) begin
               rsp_in.value_out = root_value;
            end else begin
               rsp_in.status    = ST_BAD_INDEX;
               rsp_in.index_out = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         count_ff         <= '0;
         tol_ff           <= TOL_RESET;
         ctl_ff.en_insert <= 1'b0;
         ctl_ff.en_find   <= 1'b0;
         ctl_ff.en_remove <= 1'b0;
         ctl_ff.en_read   <= 1'b0;
      end else begin
         if (psel && penable && pwrite && (paddr[2] == REG_TOLERANCE)) begin
            tol_ff <= pwdata[15:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff            <= req_data.req_type;
                  key_ff           <= k_s[IDXW-1:0];
                  ok_ff            <= (req_data.req_type == OP_INSERT) ? !full : idx_ok;
                  ctl_ff.en_insert <= (req_data.req_type == OP_INSERT) && !full;
                  ctl_ff.en_find   <= req_data.req_type == OP_FIND;
                  ctl_ff.en_remove <= (req_data.req_type == OP_REMOVE) && idx_ok;
                  ctl_ff.en_read   <= (req_data.req_type == OP_READ) && idx_ok;
                  ctl_ff.val       <= req_data.data_value;
                  ctl_ff.lo        <= lo_in;
                  ctl_ff.hi        <= hi_in;
                  state_ff         <= S_EVAL;
               end
            end
            S_EVAL: begin
               // cells shift and leaves latch at this edge
               ctl_ff.en_insert <= 1'b0;
               ctl_ff.en_find   <= 1'b0;
               ctl_ff.en_remove <= 1'b0;
               ctl_ff.en_read   <= 1'b0;
               if (ctl_ff.en_insert) begin
                  count_ff <= count_ff + 1'b1;
               end else if (ctl_ff.en_remove) begin
                  count_ff <= count_ff - 1'b1;
               end
               drain_ff <= DCW'(IDXW);
               state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               if (drain_ff != '0) begin
                  drain_ff <= drain_ff - 1'b1;
               end else if (rsp_free) begin
                  rsp_data_ff  <= rsp_in;
                  state_ff     <= S_IDLE;
               end else begin
                  // park the word, the tree drains to zero behind it
                  pend_ff  <= rsp_in;
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (rsp_free) begin
                  rsp_data_ff  <= pend_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/sae_checker.sv
// Port-level checks for the sorted array engine, bound to the top level.
module sae_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input sae_pkg::rsp_item_type rsp_data
);
   import sae_pkg::*;

   // a held response word must not change or vanish
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // one request in flight: no acceptance right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL)
      |-> (rsp_data.index_out == '0) && (rsp_data.value_out == '0))
      else $error("full response carries index or value");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == ST_NOT_FOUND) || (rsp_data.status == ST_BAD_INDEX))
      |-> (rsp_data.index_out == '0) && (rsp_data.value_out == '0))
      else $error("failed lookup carries index or value");

endmodule

bind sorted_array_engine sae_checker u_sae_checker (.*);
